### rtl/core/audio_envelope_follower_defines.svh
// ----------------------------------------------------------------------------
// Envelope follower assertion macros
// Shared assertion forms for the checker, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_ENVELOPE_FOLLOWER_DEFINES_SVH
`define AUDIO_ENVELOPE_FOLLOWER_DEFINES_SVH

// same-cycle implication
`define AEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/aef_pkg.sv
// ----------------------------------------------------------------------------
// Envelope follower package
// Shared constants, register indexes and the sequencer control word.
// ----------------------------------------------------------------------------
package aef_pkg;

    localparam int COEFF_FRAC_BITS = 24;
    localparam int COEFF_W         = 24;
    localparam int SAMPLE_W        = 16;
    localparam int LEVEL_W         = 16;
    localparam int LVL_W           = 32;
    localparam int LEVEL_FRAC      = 15;
    localparam int CFG_IDX_W       = 2;

    // full output range over converter half range, both powers of two
    localparam int HALF_SCALE      = 32768;
    localparam int OUT_RANGE       = 65536;
    localparam int OUT_SHIFT       = LEVEL_FRAC + $clog2(HALF_SCALE) - $clog2(OUT_RANGE);
    localparam int LEVEL_MAX_INT   = (OUT_RANGE - 1 > 65535) ? 65535 : OUT_RANGE - 1;
    localparam logic [LVL_W-1:0] LEVEL_MAX = LVL_W'(LEVEL_MAX_INT);

    // multiplier slice of the coefficient
    localparam int CHUNK_W         = 17;
    localparam int DIFF_W          = LVL_W + 1;

    localparam logic [COEFF_W-1:0] ATTACK_RESET  = 24'd16431480;
    localparam logic [COEFF_W-1:0] RELEASE_RESET = 24'd16776866;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

    typedef struct packed {
        logic idle;
        logic mac_start;
        logic sel_atk;
        logic peak_ld;
        logic out_ld;
    } t_seq_ctl;

endpackage

### rtl/core/aef_mac.sv
// ----------------------------------------------------------------------------
// Envelope follower multiply-accumulate unit
// Multiplies the coefficient by a signed difference one slice at a time,
// most significant slice first, with a registered product stage.
// ----------------------------------------------------------------------------
module aef_mac #(
    parameter int COEFF_BITS = aef_pkg::COEFF_FRAC_BITS + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [COEFF_BITS-1:0]             i_coeff,
    input  logic signed [aef_pkg::DIFF_W-1:0] i_diff,
    output logic                              o_done,
    output logic signed [((COEFF_BITS + aef_pkg::CHUNK_W - 1) / aef_pkg::CHUNK_W)
                         * aef_pkg::CHUNK_W + 34 - 1:0] o_acc
);

    localparam int CW    = aef_pkg::CHUNK_W;
    localparam int NC    = (COEFF_BITS + CW - 1) / CW;
    localparam int PAD_W = NC * CW;
    localparam int ACC_W = PAD_W + 34;
    localparam int PW    = CW + 1 + aef_pkg::DIFF_W;
    localparam int CNT_W = $clog2(NC + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_pv;
    logic                    r_pfirst;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic [PAD_W-1:0]        coeff_pad;
    logic [CNT_W-1:0]        idx;
    logic [CW-1:0]           chunk;
    logic                    mul_now;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [PW-1:0]    n_prod;

    assign coeff_pad = PAD_W'(i_coeff);
    assign idx       = CNT_W'(NC - 1) - r_cnt;
    assign mul_now   = r_busy && (r_cnt < CNT_W'(NC));
    assign prod_ext  = $signed({{(ACC_W - PW){r_prod[PW-1]}}, r_prod});

    always_comb begin
        chunk = '0;
        if (mul_now) begin
            chunk = coeff_pad[idx*CW +: CW];
        end
        n_prod = $signed({1'b0, chunk}) * i_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_pv   <= mul_now;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                if (mul_now) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_now) begin
            r_prod   <= n_prod;
            r_pfirst <= (r_cnt == '0);
        end
        if (r_pv) begin
            r_acc <= r_pfirst ? prod_ext : (r_acc <<< CW) + prod_ext;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

### rtl/core/aef_seq.sv
// ----------------------------------------------------------------------------
// Envelope follower sequencer
// Steps one sample through the release pole, the peak hold and the attack
// pole, then hands the level to the output register.
// ----------------------------------------------------------------------------
module aef_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_mac_done,
    input  logic              i_out_free,
    output aef_pkg::t_seq_ctl o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REL  = 3'd1;
    localparam logic [2:0] S_PEAK = 3'd2;
    localparam logic [2:0] S_ATK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.idle      = 1'b1;
                o_ctl.mac_start = i_accept;
                if (i_accept) begin
                    n_state = S_REL;
                end
            end
            S_REL: begin
                if (i_mac_done) begin
                    n_state = S_PEAK;
                end
            end
            S_PEAK: begin
                o_ctl.peak_ld   = 1'b1;
                o_ctl.mac_start = 1'b1;
                n_state         = S_ATK;
            end
            S_ATK: begin
                o_ctl.sel_atk = 1'b1;
                if (i_mac_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_ctl.sel_atk = 1'b1;
                if (i_out_free) begin
                    o_ctl.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/audio_envelope_follower.sv
// ----------------------------------------------------------------------------
// Audio envelope follower
// Peak envelope follower with attack and release poles.
// ----------------------------------------------------------------------------
// Takes one signed sample per word and returns one 16-bit level word. Each
// pole runs on one 17-bit-slice multiplier, shared between the release and
// the attack pole, which run one after the other; the coefficient is taken
// in N = ceil((COEFF_FRAC_BITS+1)/17) slices. The input is ready only while
// the sequencer is idle; a finished level waits in the output register while
// the next sample is taken, and a level that finds the output register still
// full holds the sequencer until it frees. Coefficient registers are
// Q0.COEFF_FRAC_BITS; writing either one clears the peak and smoothed levels,
// but a peak or output load in the same cycle takes precedence over the clear.
module audio_envelope_follower #(
    parameter int COEFF_FRAC_BITS = aef_pkg::COEFF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [aef_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [aef_pkg::LEVEL_W-1:0]       o_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aef_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aef_pkg::COEFF_W-1:0]       i_cfg_data
);

    localparam int AW    = COEFF_FRAC_BITS + 1;
    localparam int CFW   = (aef_pkg::COEFF_W > AW) ? aef_pkg::COEFF_W : AW;
    localparam int NC    = (AW + aef_pkg::CHUNK_W - 1) / aef_pkg::CHUNK_W;
    localparam int ACC_W = NC * aef_pkg::CHUNK_W + 34;
    localparam int LW    = aef_pkg::LVL_W;
    localparam int MAG_W = aef_pkg::SAMPLE_W + 1;
    localparam logic [CFW-1:0] COEFF_ONE = CFW'(1) << COEFF_FRAC_BITS;

    logic [aef_pkg::COEFF_W-1:0] r_attack;
    logic [aef_pkg::COEFF_W-1:0] r_release;
    logic [LW-1:0]               r_peak;
    logic [LW-1:0]               r_smooth;
    logic [LW-1:0]               r_x;
    logic                        r_out_valid;
    logic [aef_pkg::LEVEL_W-1:0] r_level;

    aef_pkg::t_seq_ctl           ctl;
    logic                        accept;
    logic                        cfg_we;
    logic                        mac_done;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     acc_sh;
    logic [CFW-1:0]              coeff_ext;
    logic [CFW-1:0]              coeff_sat;
    logic [AW-1:0]               coeff;
    logic [LW-1:0]               old_sel;
    logic [LW-1:0]               tgt_sel;
    logic signed [aef_pkg::DIFF_W-1:0] diff;
    logic [LW:0]                 pole_sum;
    logic [LW-1:0]               pole;
    logic [MAG_W-1:0]            mag;
    logic [LW-1:0]               x_in;
    logic [LW-1:0]               shifted;
    logic [aef_pkg::LEVEL_W-1:0] level_sat;

    assign accept      = i_valid && o_ready;
    assign cfg_we      = i_cfg_valid;
    assign o_ready     = ctl.idle;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_level     = r_level;

    // rectify: most negative sample keeps its full magnitude
    always_comb begin
        if (i_sample[aef_pkg::SAMPLE_W-1]) begin
            mag = MAG_W'(0) - {1'b1, i_sample};
        end else begin
            mag = {1'b0, i_sample};
        end
        x_in = LW'(mag) << aef_pkg::LEVEL_FRAC;
    end

    // pole operands and saturated coefficient
    always_comb begin
        coeff_ext = ctl.sel_atk ? CFW'(r_attack) : CFW'(r_release);
        coeff_sat = (coeff_ext > COEFF_ONE) ? COEFF_ONE : coeff_ext;
        coeff     = AW'(coeff_sat);
        old_sel   = ctl.sel_atk ? r_smooth : r_peak;
        tgt_sel   = ctl.sel_atk ? r_peak : r_x;
        diff      = $signed({1'b0, old_sel}) - $signed({1'b0, tgt_sel});
        acc_sh    = acc >>> COEFF_FRAC_BITS;
        pole_sum  = acc_sh[LW:0] + {1'b0, tgt_sel};
        pole      = pole_sum[LW-1:0];
        shifted   = pole >> aef_pkg::OUT_SHIFT;
        level_sat = (shifted > aef_pkg::LEVEL_MAX) ?
                    aef_pkg::LEVEL_W'(aef_pkg::LEVEL_MAX) :
                    shifted[aef_pkg::LEVEL_W-1:0];
    end

    aef_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_mac_done (mac_done),
        .i_out_free (!r_out_valid || i_ready),
        .o_ctl      (ctl)
    );

    aef_mac #(
        .COEFF_BITS (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.mac_start),
        .i_coeff (coeff),
        .i_diff  (diff),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= aef_pkg::ATTACK_RESET;
            r_release   <= aef_pkg::RELEASE_RESET;
            r_peak      <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we && (i_cfg_index == aef_pkg::REG_ATTACK ||
                           i_cfg_index == aef_pkg::REG_RELEASE)) begin
                if (i_cfg_index == aef_pkg::REG_ATTACK) begin
                    r_attack <= i_cfg_data;
                end else begin
                    r_release <= i_cfg_data;
                end
                r_peak   <= '0;
                r_smooth <= '0;
            end
            if (ctl.peak_ld) begin
                r_peak <= (r_x > pole) ? r_x : pole;
            end
            if (ctl.out_ld) begin
                r_smooth <= pole;
            end
            if (ctl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= x_in;
        end
        if (ctl.out_ld) begin
            r_level <= level_sat;
        end
    end

endmodule

### rtl/core/aef_checker.sv
// ----------------------------------------------------------------------------
// Envelope follower port checker
// Watches the top-level handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_envelope_follower_defines.svh"

module aef_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [aef_pkg::LEVEL_W-1:0]       o_level,
    input logic                              o_cfg_ready
);

    `AEF_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accept")
    `AEF_ASSERT_NEXT(a_no_instant_level, i_valid && o_ready && !o_valid, !o_valid, "level too early")
    `AEF_ASSERT_NEXT(a_level_held, o_valid && !i_ready, o_valid && $stable(o_level), "level dropped")
    `AEF_ASSERT_NOW(a_cfg_open, 1'b1, o_cfg_ready, "config port stalled")

endmodule

bind audio_envelope_follower aef_checker u_aef_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_level     (o_level),
    .o_cfg_ready (o_cfg_ready)
);
